// ===== rtl/core/bdc_pkg.sv =====
package bdc_pkg;

  // store geometry
  localparam int SEEN_DEPTH = 2048;
  localparam int NUM_CELLS  = 16;
  localparam int CELL_DEPTH = SEEN_DEPTH / NUM_CELLS;
  localparam int IDX_W      = $clog2(SEEN_DEPTH);
  localparam int CNT_W      = $clog2(SEEN_DEPTH + 1);
  localparam int CELL_W     = $clog2(NUM_CELLS);
  localparam int ADDR_W     = $clog2(CELL_DEPTH);

  // field widths
  localparam int BLK_W  = 32;
  localparam int LOG_W  = 11;
  localparam int KIND_W = 2;
  localparam int VERD_W = 3;
  localparam int TOT_W  = 16;

  localparam logic [TOT_W-1:0] TOTAL_MAX = '1;

  localparam int IN_DATA_W  = ((BLK_W + LOG_W + 7) / 8) * 8;
  localparam int IN_PAD_W   = IN_DATA_W - BLK_W - LOG_W;
  localparam int OUT_FLD_W  = VERD_W + BLK_W + LOG_W + TOT_W;
  localparam int OUT_DATA_W = ((OUT_FLD_W + 7) / 8) * 8;
  localparam int OUT_PAD_W  = OUT_DATA_W - OUT_FLD_W;

  localparam int CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FIRST_VALID = 1'b0,
    REG_BLOCK_COUNT = 1'b1
  } cfg_reg_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_START  = 2'd0,
    KIND_DIRECT = 2'd1,
    KIND_TABLE  = 2'd2,
    KIND_ENTRY  = 2'd3
  } kind_t;

  typedef enum logic [VERD_W-1:0] {
    V_SKIPPED  = 3'd0,
    V_ACCEPTED = 3'd1,
    V_RANGE    = 3'd2,
    V_REPEATED = 3'd3,
    V_CYCLIC   = 3'd4,
    V_FULL     = 3'd5
  } verdict_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_SEARCH,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  // search token passed from cell to cell
  typedef struct packed {
    logic              active;
    logic              last;
    logic [ADDR_W-1:0] addr;
    logic              hit;
  } tok_t;

  // store write, broadcast to every cell
  typedef struct packed {
    logic              en;
    logic [CELL_W-1:0] bank;
    logic [ADDR_W-1:0] addr;
    logic [BLK_W-1:0]  data;
  } wr_t;

endpackage

// ===== rtl/core/block_reference_dedup_checker.sv =====
// Checks the block references of one file, one item at a time, and returns one
// verdict item per input item: skipped, accepted, out of range, repeated, cyclic
// or store full, with the block, logical index and kind echoed and the running
// corruption total (saturating at 65535, kept across files). A start item clears
// the seen set and the current indirect-table block. The seen set is held in a
// row of 16 cells, each owning 128 words of the 2048-entry store; a repeat search
// sends one token per bank row down the row of cells, one cell per cycle. An item
// that needs no search (start, empty slot, cyclic, out of range, or empty set)
// goes from evaluation to the finish state. An item that searches a set of n
// entries feeds one token per row of 16 entries into the chain each cycle, then
// drains until the last token has crossed all 16 cells. The input is taken again
// as soon as the result sits in the output register, even while that result
// still waits downstream. The store needs no clearing pass after reset; only
// entries below the fill count are compared. Configuration (index 0 first valid
// block, index 1 block count) is for the user to write while idle; unenforced.
module block_reference_dedup_checker_core import bdc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // configuration write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [BLK_W-1:0]      cfg_data,
  // input items
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // block_number, logical_pos, zero pad
  input  logic [KIND_W-1:0]     s_axis_tuser,   // kind
  // result items
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // verdict, ref_block, ref_logical,
                                                // corruption_total, zero pad
  output logic [KIND_W-1:0]     m_axis_tuser    // ref_kind
);

  state_t            state, state_next;

  // configuration
  logic [BLK_W-1:0]  first_valid;
  logic [BLK_W-1:0]  block_count;

  // persistent state
  logic [CNT_W-1:0]  seen_count;
  logic [BLK_W-1:0]  tbl_block;
  logic [TOT_W-1:0]  flag_total;
  logic [TOT_W-1:0]  total_next;

  // item under check
  kind_t             it_kind;
  logic [BLK_W-1:0]  it_blk;
  logic [LOG_W-1:0]  it_log;
  verdict_t          verdict;

  // search sequencer
  logic [ADDR_W-1:0] issue_addr;
  logic [ADDR_W-1:0] last_addr;
  logic [IDX_W-1:0]  cnt_m1;
  logic              hit_acc;
  logic              hit_now;
  logic              search_done;
  tok_t              tok_in, tok_out;
  wr_t               wr;

  // evaluation of the checks that need no search
  verdict_t          eval_verdict;
  logic              eval_search;
  logic              is_flag;

  // output register
  logic              out_valid;
  verdict_t          out_verdict;
  logic [BLK_W-1:0]  out_blk;
  logic [LOG_W-1:0]  out_log;
  kind_t             out_kind;
  logic [TOT_W-1:0]  out_total;

  logic              in_fire;
  logic              fin_go;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign fin_go        = (state == ST_FINISH) && (!out_valid || m_axis_tready);

  // start first, then cyclic check, empty slot, range, empty set, then the set search
  always_comb begin
    eval_verdict = V_SKIPPED;
    eval_search  = 1'b0;
    priority if (it_kind == KIND_START) begin
      eval_verdict = V_SKIPPED;
    end else if (it_kind == KIND_ENTRY && it_blk != '0 && it_blk == tbl_block) begin
      eval_verdict = V_CYCLIC;
    end else if (it_blk == '0) begin
      eval_verdict = V_SKIPPED;
    end else if (it_blk < first_valid || it_blk >= block_count) begin
      eval_verdict = V_RANGE;
    end else if (seen_count == '0) begin
      eval_verdict = V_ACCEPTED;
    end else begin
      eval_search = 1'b1;
    end
  end

  assign cnt_m1      = IDX_W'(seen_count - CNT_W'(1));
  assign hit_now     = hit_acc | (tok_out.active & tok_out.hit);
  assign search_done = (state == ST_DRAIN) && tok_out.active && tok_out.last;

  // one token per bank row while searching
  always_comb begin
    tok_in        = '0;
    tok_in.active = (state == ST_SEARCH);
    tok_in.last   = (state == ST_SEARCH) && (issue_addr == last_addr);
    tok_in.addr   = issue_addr;
  end

  bdc_chain u_chain (
    .clk        (clk),
    .rst        (rst),
    .seen_count (seen_count),
    .key        (it_blk),
    .wr         (wr),
    .tok_in     (tok_in),
    .tok_out    (tok_out)
  );

  // new entry goes to cell count mod 16, row count / 16
  always_comb begin
    wr.en   = fin_go && (verdict == V_ACCEPTED);
    wr.bank = seen_count[CELL_W-1:0];
    wr.addr = seen_count[IDX_W-1:CELL_W];
    wr.data = it_blk;
  end

  assign is_flag    = (verdict == V_RANGE) || (verdict == V_REPEATED) ||
                      (verdict == V_CYCLIC);
  assign total_next = (is_flag && flag_total != TOTAL_MAX) ? flag_total + TOT_W'(1)
                                                           : flag_total;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_fire) state_next = ST_EVAL;
      ST_EVAL:   state_next = eval_search ? ST_SEARCH : ST_FINISH;
      ST_SEARCH: if (issue_addr == last_addr) state_next = ST_DRAIN;
      ST_DRAIN:  if (search_done) state_next = ST_FINISH;
      ST_FINISH: if (fin_go) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // item and search datapath
  always_ff @(posedge clk) begin
    if (in_fire) begin
      it_kind <= kind_t'(s_axis_tuser);
      it_blk  <= s_axis_tdata[BLK_W-1:0];
      it_log  <= s_axis_tdata[BLK_W+LOG_W-1:BLK_W];
    end
    if (state == ST_EVAL) begin
      verdict    <= eval_verdict;
      hit_acc    <= 1'b0;
      issue_addr <= '0;
      last_addr  <= cnt_m1[IDX_W-1:CELL_W];
    end else begin
      if (state == ST_SEARCH) begin
        issue_addr <= issue_addr + ADDR_W'(1);
      end
      if (tok_out.active && tok_out.hit) begin
        hit_acc <= 1'b1;
      end
      if (search_done) begin
        priority if (hit_now) begin
          verdict <= V_REPEATED;
        end else if (seen_count == CNT_W'(SEEN_DEPTH)) begin
          verdict <= V_FULL;
        end else begin
          verdict <= V_ACCEPTED;
        end
      end
    end
  end

  // configuration and persistent state
  always_ff @(posedge clk) begin
    if (rst) begin
      first_valid <= BLK_W'(1);
      block_count <= '0;
      seen_count  <= '0;
      tbl_block   <= '0;
      flag_total  <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_FIRST_VALID: first_valid <= cfg_data;
          REG_BLOCK_COUNT: block_count <= cfg_data;
          default: ;
        endcase
      end
      if (fin_go) begin
        flag_total <= total_next;
        if (it_kind == KIND_START) begin
          seen_count <= '0;
          tbl_block  <= '0;
        end else begin
          if (it_kind == KIND_TABLE) begin
            tbl_block <= it_blk;
          end
          if (verdict == V_ACCEPTED) begin
            seen_count <= seen_count + CNT_W'(1);
          end
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_go) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      out_verdict <= verdict;
      out_blk     <= it_blk;
      out_log     <= it_log;
      out_kind    <= it_kind;
      out_total   <= total_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_total, out_log, out_blk, out_verdict};
  assign m_axis_tuser  = out_kind;

  // store fill never passes its depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    seen_count <= CNT_W'(SEEN_DEPTH))
    else $error("seen count beyond store depth");

  // the set must not change under a running search
  a_count_stable: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEARCH || state == ST_DRAIN) |=> $stable(seen_count))
    else $error("seen count changed during search");

  // the final token only comes out of the chain after issuing has ended
  a_last_in_drain: assert property (@(posedge clk) disable iff (rst)
    (tok_out.active && tok_out.last) |-> (state == ST_DRAIN))
    else $error("final search token outside drain");

  // corruption total never goes down
  a_total_mono: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> flag_total >= $past(flag_total))
    else $error("corruption total decreased");

  // a stored entry is always a nonzero in-range block
  a_write_valid: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> (it_blk != '0 && it_blk >= first_valid && it_blk < block_count))
    else $error("invalid block written to store");

endmodule

// ===== rtl/core/bdc_cell.sv =====
module bdc_cell import bdc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [CELL_W-1:0] cell_idx,
  input  logic [CNT_W-1:0]  seen_count,
  input  logic [BLK_W-1:0]  key,
  input  wr_t               wr,
  input  tok_t              tok_in,
  output tok_t              tok_out
);

  logic [BLK_W-1:0] mem [CELL_DEPTH];
  logic [BLK_W-1:0] rdata;
  tok_t             tok_q;
  logic [IDX_W-1:0] entry_idx;
  logic             live;

  // bank of the store: entry j lives in cell j mod NUM_CELLS
  always_ff @(posedge clk) begin
    if (wr.en && wr.bank == cell_idx) begin
      mem[wr.addr] <= wr.data;
    end
    rdata <= mem[tok_in.addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_in;
    end
  end

  assign entry_idx = {tok_q.addr, cell_idx};
  assign live      = {1'b0, entry_idx} < seen_count;

  always_comb begin
    tok_out     = tok_q;
    tok_out.hit = tok_q.hit | (tok_q.active & live & (rdata == key));
  end

endmodule

// ===== rtl/core/bdc_chain.sv =====
module bdc_chain import bdc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [CNT_W-1:0] seen_count,
  input  logic [BLK_W-1:0] key,
  input  wr_t              wr,
  input  tok_t             tok_in,
  output tok_t             tok_out
);

  tok_t tok [NUM_CELLS+1];

  assign tok[0] = tok_in;

  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    bdc_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cell_idx   (CELL_W'(k)),
      .seen_count (seen_count),
      .key        (key),
      .wr         (wr),
      .tok_in     (tok[k]),
      .tok_out    (tok[k+1])
    );
  end

  assign tok_out = tok[NUM_CELLS];

endmodule
